@@ hw/rtl/dfst_pkg.sv @@
package dfst_pkg;

    // Default sizes of the graph store.
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_ARCS_DEF     = 256;

    // Fixed field widths.
    localparam int VTX_W      = 6;
    localparam int STAMP_W    = 8;
    localparam int CNT_W      = 7;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RECORD = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_DISC,
        S_HEAD,
        S_STEP,
        S_ARC,
        S_FIN,
        S_POP,
        S_END
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                take;
        logic                add_store;
        logic                add_link;
        logic                put_simple;
        logic [STATUS_W-1:0] simple_code;
        logic                clear_arcs;
        logic                run_start;
        logic                scan_next;
        logic                pick_root;
        logic                pick_arc;
        logic                cursor_adv;
        logic                discover;
        logic                head_load;
        logic                rec_push;
        logic                pop_load;
        logic                flush_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              range_ok;
        logic              store_full;
        logic              scan_done;
        logic              scan_visited;
        logic              cursor_live;
        logic              arc_new;
        logic              stack_left;
        logic              held_valid;
        logic              out_free;
    } stat_t;

endpackage

@@ hw/rtl/dfst_ram.sv @@
module dfst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/dfst_ctrl.sv @@
module dfst_ctrl
    import dfst_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   take;

    assign s_tready = (state_reg == S_IDLE) && stat.out_free;
    assign take     = s_tvalid && s_tready;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take && stat.kind == KIND_ADD && stat.range_ok && !stat.store_full)
                begin
                    state_next = S_ADD;
                end
                else if (take && stat.kind == KIND_RUN)
                begin
                    state_next = S_SCAN;
                end
            end
            S_ADD:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_END;
                end
                else if (!stat.scan_visited)
                begin
                    state_next = S_DISC;
                end
            end
            S_DISC:
            begin
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                state_next = S_STEP;
            end
            S_STEP:
            begin
                state_next = stat.cursor_live ? S_ARC : S_FIN;
            end
            S_ARC:
            begin
                state_next = stat.arc_new ? S_DISC : S_STEP;
            end
            S_FIN:
            begin
                if (!stat.held_valid || stat.out_free)
                begin
                    state_next = stat.stack_left ? S_POP : S_SCAN;
                end
            end
            S_POP:
            begin
                state_next = S_STEP;
            end
            S_END:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd      = '0;
        cmd.take = take;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (stat.kind)
                        KIND_ADD:
                        begin
                            if (!stat.range_ok)
                            begin
                                cmd.put_simple  = 1'b1;
                                cmd.simple_code = ST_RANGE;
                            end
                            else if (stat.store_full)
                            begin
                                cmd.put_simple  = 1'b1;
                                cmd.simple_code = ST_FULL;
                            end
                            else
                            begin
                                cmd.add_store = 1'b1;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            cmd.clear_arcs  = 1'b1;
                            cmd.put_simple  = 1'b1;
                            cmd.simple_code = ST_OK;
                        end
                        KIND_RUN:
                        begin
                            cmd.run_start = 1'b1;
                        end
                        default:
                        begin
                            cmd.put_simple = 1'b0;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.add_link    = 1'b1;
                cmd.put_simple  = 1'b1;
                cmd.simple_code = ST_OK;
            end
            S_SCAN:
            begin
                if (!stat.scan_done)
                begin
                    cmd.scan_next = stat.scan_visited;
                    cmd.pick_root = !stat.scan_visited;
                end
            end
            S_DISC:
            begin
                cmd.discover = 1'b1;
            end
            S_HEAD:
            begin
                cmd.head_load = 1'b1;
            end
            S_ARC:
            begin
                cmd.cursor_adv = 1'b1;
                cmd.pick_arc   = stat.arc_new;
            end
            S_FIN:
            begin
                cmd.rec_push = !stat.held_valid || stat.out_free;
            end
            S_POP:
            begin
                cmd.pop_load = 1'b1;
            end
            S_END:
            begin
                cmd.flush_last = stat.out_free;
            end
            default:
            begin
                cmd.take = take;
            end
        endcase
    end

endmodule

@@ hw/rtl/dfst_dp.sv @@
module dfst_dp
    import dfst_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_ARCS     = MAX_ARCS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]   m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CNT_W-1:0]      cfg_wdata,
    input  cmd_t                  cmd,
    output stat_t                 stat
);

    localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int AAW = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
    localparam int AIW = $clog2(MAX_ARCS + 1);
    localparam int SPW = $clog2(MAX_VERTICES + 1);
    localparam int SKW = VTX_W + AIW;
    localparam int PRW = VTX_W + 1;
    localparam int RECW = OUT_DATA_W - 5;
    localparam logic [AIW-1:0] NIL = AIW'(MAX_ARCS);

    // Input fields.
    logic [VTX_W-1:0] in_from, in_to;
    assign in_from = s_tdata[VTX_W-1:0];
    assign in_to   = s_tdata[2*VTX_W-1:VTX_W];

    // Control registers.
    logic [CNT_W-1:0]        vcount_reg;
    logic [AIW-1:0]          arc_count_reg;
    logic [MAX_VERTICES-1:0] head_ok_reg;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [CNT_W-1:0]        scan_reg;
    logic [SPW-1:0]          sp_reg;
    logic [STAMP_W-1:0]      clock_reg;
    logic                    held_valid_reg;
    logic                    out_valid_reg;

    // Payload registers.
    logic [VTX_W-1:0]     from_reg;
    logic [AAW-1:0]       idx_reg;
    logic [VTX_W-1:0]     dv_reg;
    logic [VTX_W-1:0]     dpar_reg;
    logic                 dpv_reg;
    logic [VTX_W-1:0]     root_reg;
    logic [VTX_W-1:0]     top_v_reg;
    logic [AIW-1:0]       top_c_reg;
    logic [RECW-1:0]      held_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic                 out_last_reg;

    // Memory ports.
    logic [VTX_W-1:0]   tgt_rdata;
    logic [AIW-1:0]     next_rdata;
    logic [AAW-1:0]     head_rdata;
    logic [AAW-1:0]     tail_rdata;
    logic [STAMP_W-1:0] dtime_rdata;
    logic [PRW-1:0]     par_rdata;
    logic [SKW-1:0]     stk_rdata;
    logic               next_we;
    logic [AAW-1:0]     next_waddr;
    logic [AIW-1:0]     next_wdata;
    logic               head_we;

    logic [CNT_W-1:0]   n_eff;
    logic [STAMP_W-1:0] clock_inc;
    logic [RECW-1:0]    new_rec;
    logic               out_free;

    // Effective vertex count, clamped to the supported range.
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (vcount_reg > CNT_W'(MAX_VERTICES))
        begin
            n_eff = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_eff = vcount_reg;
        end
    end

    assign clock_inc = clock_reg + STAMP_W'(1);
    assign out_free  = !out_valid_reg || m_tready;

    // Status toward the controller.
    always_comb
    begin
        stat.kind         = s_tuser;
        stat.range_ok     = ({1'b0, in_from} < n_eff) && ({1'b0, in_to} < n_eff);
        stat.store_full   = arc_count_reg >= AIW'(MAX_ARCS);
        stat.scan_done    = scan_reg >= n_eff;
        stat.scan_visited = visited_reg[scan_reg[VAW-1:0]];
        stat.cursor_live  = top_c_reg < arc_count_reg;
        stat.arc_new      = ({1'b0, tgt_rdata} < n_eff) && !visited_reg[tgt_rdata[VAW-1:0]]
                            && (sp_reg < SPW'(MAX_VERTICES));
        stat.stack_left   = sp_reg > SPW'(1);
        stat.held_valid   = held_valid_reg;
        stat.out_free     = out_free;
    end

    // Record for the vertex that finishes now:
    // vertex, discovery, finish, parent, has_parent, root.
    assign new_rec = {root_reg, par_rdata[VTX_W], par_rdata[VTX_W-1:0],
                      clock_inc, dtime_rdata, top_v_reg};

    // Arc store.
    assign next_we    = cmd.add_store || (cmd.add_link && head_ok_reg[from_reg[VAW-1:0]]);
    assign next_waddr = cmd.add_store ? arc_count_reg[AAW-1:0] : tail_rdata;
    assign next_wdata = cmd.add_store ? NIL : AIW'(idx_reg);
    assign head_we    = cmd.add_link && !head_ok_reg[from_reg[VAW-1:0]];

    dfst_ram #(.WIDTH(VTX_W), .DEPTH(MAX_ARCS)) u_tgt_ram (
        .clk   (clk),
        .we    (cmd.add_store),
        .waddr (arc_count_reg[AAW-1:0]),
        .wdata (in_to),
        .raddr (top_c_reg[AAW-1:0]),
        .rdata (tgt_rdata)
    );

    dfst_ram #(.WIDTH(AIW), .DEPTH(MAX_ARCS)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (top_c_reg[AAW-1:0]),
        .rdata (next_rdata)
    );

    dfst_ram #(.WIDTH(AAW), .DEPTH(MAX_VERTICES)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (from_reg[VAW-1:0]),
        .wdata (idx_reg),
        .raddr (dv_reg[VAW-1:0]),
        .rdata (head_rdata)
    );

    dfst_ram #(.WIDTH(AAW), .DEPTH(MAX_VERTICES)) u_tail_ram (
        .clk   (clk),
        .we    (cmd.add_link),
        .waddr (from_reg[VAW-1:0]),
        .wdata (idx_reg),
        .raddr (in_from[VAW-1:0]),
        .rdata (tail_rdata)
    );

    // Per-vertex search state.
    dfst_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_VERTICES)) u_dtime_ram (
        .clk   (clk),
        .we    (cmd.discover),
        .waddr (dv_reg[VAW-1:0]),
        .wdata (clock_inc),
        .raddr (top_v_reg[VAW-1:0]),
        .rdata (dtime_rdata)
    );

    dfst_ram #(.WIDTH(PRW), .DEPTH(MAX_VERTICES)) u_par_ram (
        .clk   (clk),
        .we    (cmd.discover),
        .waddr (dv_reg[VAW-1:0]),
        .wdata ({dpv_reg, dpar_reg}),
        .raddr (top_v_reg[VAW-1:0]),
        .rdata (par_rdata)
    );

    // Walk stack below the cached top entry.
    dfst_ram #(.WIDTH(SKW), .DEPTH(MAX_VERTICES)) u_stk_ram (
        .clk   (clk),
        .we    (cmd.discover && sp_reg != '0),
        .waddr (VAW'(sp_reg - SPW'(1))),
        .wdata ({top_v_reg, top_c_reg}),
        .raddr (VAW'(sp_reg - SPW'(2))),
        .rdata (stk_rdata)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg     <= VCOUNT_RESET;
            arc_count_reg  <= '0;
            head_ok_reg    <= '0;
            visited_reg    <= '0;
            scan_reg       <= '0;
            sp_reg         <= '0;
            clock_reg      <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
            if (cmd.add_store)
            begin
                arc_count_reg <= arc_count_reg + AIW'(1);
            end
            if (cmd.clear_arcs)
            begin
                arc_count_reg <= '0;
                head_ok_reg   <= '0;
            end
            if (head_we)
            begin
                head_ok_reg[from_reg[VAW-1:0]] <= 1'b1;
            end
            if (cmd.run_start)
            begin
                visited_reg    <= '0;
                scan_reg       <= '0;
                sp_reg         <= '0;
                clock_reg      <= '0;
                held_valid_reg <= 1'b0;
            end
            if (cmd.scan_next)
            begin
                scan_reg <= scan_reg + CNT_W'(1);
            end
            if (cmd.discover)
            begin
                visited_reg[dv_reg[VAW-1:0]] <= 1'b1;
                clock_reg <= clock_inc;
                sp_reg    <= sp_reg + SPW'(1);
            end
            if (cmd.rec_push)
            begin
                clock_reg      <= clock_inc;
                sp_reg         <= sp_reg - SPW'(1);
                held_valid_reg <= 1'b1;
            end
            if (cmd.flush_last)
            begin
                held_valid_reg <= 1'b0;
            end
            if (cmd.put_simple || cmd.flush_last || (cmd.rec_push && held_valid_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        if (cmd.add_store)
        begin
            from_reg <= in_from;
            idx_reg  <= arc_count_reg[AAW-1:0];
        end
        if (cmd.pick_root)
        begin
            dv_reg   <= VTX_W'(scan_reg);
            root_reg <= VTX_W'(scan_reg);
            dpv_reg  <= 1'b0;
            dpar_reg <= '0;
        end
        if (cmd.pick_arc)
        begin
            dv_reg   <= tgt_rdata;
            dpv_reg  <= 1'b1;
            dpar_reg <= top_v_reg;
        end
        if (cmd.head_load)
        begin
            top_v_reg <= dv_reg;
            top_c_reg <= head_ok_reg[dv_reg[VAW-1:0]] ? AIW'(head_rdata) : NIL;
        end
        if (cmd.cursor_adv)
        begin
            top_c_reg <= next_rdata;
        end
        if (cmd.pop_load)
        begin
            top_v_reg <= stk_rdata[SKW-1:AIW];
            top_c_reg <= stk_rdata[AIW-1:0];
        end
        if (cmd.rec_push)
        begin
            held_reg <= new_rec;
        end
        if (cmd.put_simple)
        begin
            out_data_reg   <= '0;
            out_status_reg <= cmd.simple_code;
            out_last_reg   <= 1'b1;
        end
        if (cmd.rec_push && held_valid_reg)
        begin
            out_data_reg   <= OUT_DATA_W'(held_reg);
            out_status_reg <= ST_RECORD;
            out_last_reg   <= 1'b0;
        end
        if (cmd.flush_last)
        begin
            out_data_reg   <= OUT_DATA_W'(held_reg);
            out_status_reg <= ST_RECORD;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ hw/rtl/depth_first_search_timestamps.sv @@
// Channel   Direction  Ports                                   Carries
// s         in         s_tvalid s_tready s_tdata s_tuser        add arc, clear or run
// m         out        m_tvalid m_tready m_tdata m_tuser m_tlast status and visit records
// cfg       in         cfg_we cfg_wdata                         vertex count
//
// An add-arc item stores the arc at its transfer and links it in the add state; a clear
// acts at its transfer. A run's length grows with V vertices and E walked arcs, set by the
// one-read-per-cycle walk (while no result stalls) over the arc store and the stack memory.
// Reset is asynchronous and active low; it empties the arc lists at once.
// A stalled result holds the search until the output register is free.
module depth_first_search_timestamps
    import dfst_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_ARCS     = MAX_ARCS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // from_vertex[5:0], to_vertex[11:6], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // vertex[5:0], discovery[13:6], finish[21:14], parent[27:22],
    // has_parent[28], root[34:29], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]   m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CNT_W-1:0]      cfg_wdata
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer for arc loads and the search walk.
    dfst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Graph store, stack and result register.
    dfst_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_ARCS     (MAX_ARCS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ tb/dfs_record_checker.sv @@
module dfs_record_checker
    import dfst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [STATUS_W-1:0]   m_tuser,
    input  logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CNT_W-1:0]      cfg_wdata,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NVTX  = MAX_VERTICES_DEF;
    localparam int NARC  = MAX_ARCS_DEF;
    localparam int NO_ARC = NARC;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VTX_W-1:0]    vertex;
        logic [STAMP_W-1:0]  discovery;
        logic [STAMP_W-1:0]  finish;
        logic [VTX_W-1:0]    parent;
        logic                has_parent;
        logic [VTX_W-1:0]    root;
        logic                last;
    } visit_t;

    visit_t expected_results[$];

    // Shadow copy of the graph store and the vertex count register.
    logic [CNT_W-1:0] vcount;
    logic [VTX_W-1:0] arc_to [NARC];
    int               arc_link [NARC];
    int               head_arc [NVTX];
    int               tail_arc [NVTX];
    int               arcs_used;

    function automatic int active_vertices();
        if (vcount == 0) return 1;
        if (vcount > NVTX) return NVTX;
        return int'(vcount);
    endfunction

    function automatic void push_status(logic [STATUS_W-1:0] code);
        visit_t r;
        r = '0;
        r.status = code;
        r.last = 1'b1;
        expected_results.push_back(r);
    endfunction

    // Iterative depth-first search that queues one record per finished vertex.
    function automatic void predict_search();
        int n;
        int sp;
        int color [NVTX];
        int par [NVTX];
        bit par_ok [NVTX];
        logic [STAMP_W-1:0] found_at [NVTX];
        int stk_vtx [NVTX];
        int stk_arc [NVTX];
        logic [STAMP_W-1:0] stamp;
        int top;
        int u;
        int c;
        int v;
        int root;
        int emitted;
        visit_t r;
        n = active_vertices();
        sp = 0;
        stamp = '0;
        emitted = 0;
        root = 0;
        for (int i = 0; i < NVTX; i++)
        begin
            color[i] = 0;
            par[i] = 0;
            par_ok[i] = 0;
        end
        for (int s = 0; s < n; s++)
        begin
            if (color[s] != 0) continue;
            root = s;
            stamp++;
            found_at[s] = stamp;
            color[s] = 1;
            stk_vtx[sp] = s;
            stk_arc[sp] = head_arc[s];
            sp++;
            while (sp > 0)
            begin
                top = sp - 1;
                u = stk_vtx[top];
                c = stk_arc[top];
                if (c < NARC && c < arcs_used)
                begin
                    v = arc_to[c];
                    stk_arc[top] = arc_link[c];
                    if (v < n && color[v] == 0 && sp < NVTX)
                    begin
                        par[v] = u;
                        par_ok[v] = 1;
                        stamp++;
                        found_at[v] = stamp;
                        color[v] = 1;
                        stk_vtx[sp] = v;
                        stk_arc[sp] = head_arc[v];
                        sp++;
                    end
                end
                else
                begin
                    sp = top;
                    color[u] = 2;
                    stamp++;
                    r = '0;
                    r.status = ST_RECORD;
                    r.vertex = VTX_W'(u);
                    r.discovery = found_at[u];
                    r.finish = stamp;
                    r.parent = par_ok[u] ? VTX_W'(par[u]) : '0;
                    r.has_parent = par_ok[u];
                    r.root = VTX_W'(root);
                    expected_results.push_back(r);
                    emitted++;
                end
            end
        end
        if (emitted > 0)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    // Predict on each input transfer, then compare each output transfer.
    always @(posedge clk or negedge rst_n)
    begin
        logic [VTX_W-1:0] from_v;
        logic [VTX_W-1:0] to_v;
        visit_t got;
        visit_t want;
        if (!rst_n)
        begin
            vcount = VCOUNT_RESET;
            arcs_used = 0;
            for (int i = 0; i < NVTX; i++) head_arc[i] = NO_ARC;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we) vcount = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                from_v = s_tdata[5:0];
                to_v = s_tdata[11:6];
                case (s_tuser)
                    KIND_ADD:
                    begin
                        if (from_v >= active_vertices() || to_v >= active_vertices())
                            push_status(ST_RANGE);
                        else if (arcs_used >= NARC)
                            push_status(ST_FULL);
                        else
                        begin
                            arc_to[arcs_used] = to_v;
                            arc_link[arcs_used] = NO_ARC;
                            if (head_arc[from_v] == NO_ARC)
                                head_arc[from_v] = arcs_used;
                            else
                                arc_link[tail_arc[from_v]] = arcs_used;
                            tail_arc[from_v] = arcs_used;
                            arcs_used++;
                            push_status(ST_OK);
                        end
                    end
                    KIND_CLEAR:
                    begin
                        for (int i = 0; i < NVTX; i++) head_arc[i] = NO_ARC;
                        arcs_used = 0;
                        push_status(ST_OK);
                    end
                    KIND_RUN: predict_search();
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.vertex = m_tdata[5:0];
                got.discovery = m_tdata[13:6];
                got.finish = m_tdata[21:14];
                got.parent = m_tdata[27:22];
                got.has_parent = m_tdata[28];
                got.root = m_tdata[34:29];
                got.last = m_tlast;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %p",
                             $realtime, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $realtime, want, got);
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    import dfst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40000;

    // A kind that the block ignores.
    localparam logic [KIND_W-1:0] KIND_SKIP = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CNT_W-1:0]      cfg_wdata;
    int                    fail_count;
    int                    pending;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_output;
    int  quiet_cycles = 0;

    depth_first_search_timestamps DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    dfs_record_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    // Clock generation.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side readiness with random stalls and a forced hold-off.
    always @(posedge clk)
        m_tready <= !hold_output && ($urandom_range(99) >= recv_stall_pct);

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one item and return at the edge where its transfer happens.
    task automatic send_item(logic [KIND_W-1:0] kind, int from_v, int to_v);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {4'b0, to_v[5:0], from_v[5:0]};
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
    endtask

    // Let all results drain, then leave time for the block to go idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_vcount(int value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value[CNT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // A graph of random edges, mostly undirected, with some noise mixed in.
    task automatic random_graph(int vcfg, int edges);
        int n;
        int a;
        int b;
        write_vcount(vcfg);
        n = (vcfg == 0) ? 1 : (vcfg > 64 ? 64 : vcfg);
        send_item(KIND_CLEAR, $urandom_range(63), $urandom_range(63));
        for (int i = 0; i < edges; i++)
        begin
            a = $urandom_range(n - 1);
            b = $urandom_range(n - 1);
            case ($urandom_range(9))
                0: send_item(KIND_ADD, $urandom_range(63), $urandom_range(63));
                1: send_item(KIND_SKIP, $urandom_range(63), $urandom_range(63));
                2: send_item(KIND_ADD, a, b);
                default:
                begin
                    send_item(KIND_ADD, a, b);
                    send_item(KIND_ADD, b, a);
                end
            endcase
        end
        send_item(KIND_RUN, $urandom_range(63), $urandom_range(63));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        hold_output = 1'b0;
        send_idle_pct = 11;
        recv_stall_pct = 71;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty graph, extremes, self loop, ignored kind, range errors.
        send_item(KIND_RUN, 0, 0);
        send_item(KIND_ADD, 0, 63);
        send_item(KIND_ADD, 63, 0);
        send_item(KIND_ADD, 5, 5);
        send_item(KIND_ADD, 0, 1);
        send_item(KIND_ADD, 1, 2);
        send_item(KIND_SKIP, 63, 63);
        send_item(KIND_RUN, 63, 63);
        write_vcount(1);
        send_item(KIND_ADD, 0, 0);
        send_item(KIND_ADD, 0, 1);
        send_item(KIND_RUN, 0, 0);
        write_vcount(0);
        send_item(KIND_CLEAR, 0, 0);
        send_item(KIND_ADD, 1, 0);
        send_item(KIND_RUN, 0, 0);
        write_vcount(127);
        send_item(KIND_ADD, 63, 62);
        send_item(KIND_RUN, 0, 0);

        // Stale arcs once the vertex count is lowered.
        write_vcount(64);
        send_item(KIND_CLEAR, 0, 0);
        send_item(KIND_ADD, 0, 40);
        send_item(KIND_ADD, 0, 3);
        send_item(KIND_ADD, 3, 50);
        send_item(KIND_ADD, 3, 1);
        write_vcount(4);
        send_item(KIND_RUN, 0, 0);

        // Random graphs over the three idling modes.
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 71;
                recv_stall_pct = 11;
            end
            else if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            random_graph((ph % 4 == 0) ? $urandom_range(1, 127) :
                         (ph % 4 == 1) ? 64 : $urandom_range(2, 12),
                         $urandom_range(2, 5));
        end

        // Fill the arc store past its limit while the output is held off.
        write_vcount(64);
        fork
            begin
                hold_output <= 1'b1;
                repeat (400) @(posedge clk);
                hold_output <= 1'b0;
            end
        join_none
        send_item(KIND_CLEAR, 0, 0);
        for (int i = 0; i < MAX_ARCS_DEF + 3; i++)
            send_item(KIND_ADD, $urandom_range(63), $urandom_range(63));
        send_item(KIND_RUN, 0, 0);

        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
